>>> rtl/core/mlp_sigmoid_classifier_top_macros.svh
// Assertion macros shared by the classifier RTL.
// SAME checks the consequent in the cycle of the antecedent, NEXT in the cycle after it.
`ifndef MLP_SIGMOID_CLASSIFIER_TOP_MACROS_SVH
`define MLP_SIGMOID_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msc: check failed");
`define MSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msc: check failed");
`else
`define MSC_ASSERT_SAME(label, clk, rst, ante, cons)
`define MSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/msc_pkg.sv
`default_nettype none
package msc_pkg;

   // accumulator width, all sums held in Q.28
   localparam int ACC_W = 48;

   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HMAC,
      ST_HSIG,
      ST_OMAC,
      ST_OSIG,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic init;
      logic mac;
      logic out_layer;
   } lane_ctrl_type;

   // shift-subtract divide, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sigmoid at bin centre 8*m/entries, m > 0
   function automatic logic [15:0] sig_pos(input logic [63:0] m, input int entries);
      logic [63:0] y;
      logic [63:0] y2;
      logic [63:0] y3;
      logic [63:0] y4;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] r;
      y  = udiv64(m << 27, 64'(entries));
      y2 = (y * y) >> 32;
      y3 = (y2 * y) >> 32;
      y4 = (y3 * y) >> 32;
      e  = 64'h1_0000_0000 - y + y2 / 64'd2 - y3 / 64'd6 + y4 / 64'd24;
      if (e >= 64'h1_0000_0000) begin
         e = 64'hFFFF_FFFF;
      end
      for (int s = 0; s < 8; s++) begin
         e = (e * e) >> 32;
      end
      d = 64'h1_0000_0000 + e;
      r = udiv64(64'h1_0000_0000_0000 + (d >> 1), d);
      return (r > 64'd65535) ? 16'hFFFF : r[15:0];
   endfunction

   function automatic logic [15:0] sig_entry(input int k, input int entries);
      int m;
      logic [16:0] t;
      m = 2 * k + 1 - entries;
      if (m == 0) begin
         return 16'h8000;
      end
      if (m > 0) begin
         return sig_pos(64'(m), entries);
      end
      t = 17'h1_0000 - {1'b0, sig_pos(64'(-m), entries)};
      return t[15:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/msc_lane.sv
`default_nettype none
module msc_lane import msc_pkg::*; #(
   parameter int LANE     = 0,
   parameter int N_IN     = 4,
   parameter int N_HIDDEN = 5,
   parameter int N_OUT    = 3,
   parameter int IDX_W    = 6,
   parameter int STEP_W   = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lane_ctrl_type           ctrl,
   input  wire logic                    wr_en,
   input  wire logic [IDX_W-1:0]        wr_idx,
   input  wire logic [15:0]             wr_data,
   input  wire logic [STEP_W-1:0]       step,
   input  wire logic signed [16:0]      operand,
   output logic signed [ACC_W-1:0]      acc
);

   localparam int  HW_AW   = (N_IN > 1) ? $clog2(N_IN) : 1;
   localparam int  OW_AW   = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
   localparam bit  HAS_HID = (LANE < N_HIDDEN);
   localparam bit  HAS_OUT = (LANE < N_OUT);
   localparam int  HW_BASE = LANE * N_IN;
   localparam int  OW_BASE = N_IN * N_HIDDEN + LANE * N_HIDDEN;
   localparam int  HB_IDX  = N_IN * N_HIDDEN + N_HIDDEN * N_OUT + LANE;
   localparam int  OB_IDX  = N_IN * N_HIDDEN + N_HIDDEN * N_OUT + N_HIDDEN + LANE;
   localparam int  PROD_W  = 33;

   logic [15:0] hw_ff [N_IN];
   logic [15:0] hw_in [N_IN];
   logic [15:0] ow_ff [N_HIDDEN];
   logic [15:0] ow_in [N_HIDDEN];
   logic [15:0] hb_ff, hb_in, ob_ff, ob_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic signed [15:0]       weight;
   logic signed [15:0]       bias;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  term;

   // table writes, each slot decodes its own index
   always_comb begin
      hw_in = hw_ff;
      ow_in = ow_ff;
      hb_in = hb_ff;
      ob_in = ob_ff;
      for (int p = 0; p < N_IN; p++) begin
         if (HAS_HID && wr_en && (wr_idx == IDX_W'(HW_BASE + p))) begin
            hw_in[p] = wr_data;
         end
      end
      for (int p = 0; p < N_HIDDEN; p++) begin
         if (HAS_OUT && wr_en && (wr_idx == IDX_W'(OW_BASE + p))) begin
            ow_in[p] = wr_data;
         end
      end
      if (HAS_HID && wr_en && (wr_idx == IDX_W'(HB_IDX))) begin
         hb_in = wr_data;
      end
      if (HAS_OUT && wr_en && (wr_idx == IDX_W'(OB_IDX))) begin
         ob_in = wr_data;
      end
   end

   // MAC: hidden products are Q.20, moved up to Q.28
   always_comb begin
      weight   = ctrl.out_layer ? ow_ff[step[OW_AW-1:0]] : hw_ff[step[HW_AW-1:0]];
      bias     = ctrl.out_layer ? ob_ff : hb_ff;
      prod     = weight * operand;
      prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      term     = ctrl.out_layer ? prod_ext : {prod_ext[ACC_W-9:0], 8'b0};
      acc_in   = acc_ff;
      priority if (ctrl.init) begin
         acc_in = {{(ACC_W-32){bias[15]}}, bias, 16'b0};
      end else if (ctrl.mac) begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < N_IN; p++) begin
            hw_ff[p] <= '0;
         end
         for (int p = 0; p < N_HIDDEN; p++) begin
            ow_ff[p] <= '0;
         end
         hb_ff <= '0;
         ob_ff <= '0;
      end else begin
         hw_ff <= hw_in;
         ow_ff <= ow_in;
         hb_ff <= hb_in;
         ob_ff <= ob_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

>>> rtl/core/msc_sigmoid.sv
`default_nettype none
module msc_sigmoid import msc_pkg::*; #(
   parameter int SIG_ENTRIES = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic signed [ACC_W-1:0] z,
   output logic                         out_valid,
   output logic [15:0]                  act
);

   localparam int SIG_W  = $clog2(SIG_ENTRIES + 1);
   localparam int SIG_AW = $clog2(SIG_ENTRIES);
   localparam logic [SIG_W-1:0] SIG_K = SIG_W'(SIG_ENTRIES);

   logic [15:0] lut [SIG_ENTRIES];

   for (genvar k = 0; k < SIG_ENTRIES; k++) begin : g_lut
      localparam logic [15:0] ENTRY = sig_entry(k, SIG_ENTRIES);
      assign lut[k] = ENTRY;
   end

   logic              v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [31:0]       u_ff, u_in;
   logic [SIG_AW-1:0] idx_ff, idx_in;
   logic [15:0]       act_ff, act_in;
   logic [32+SIG_W-1:0] prod;
   logic              in_range;

   // clamp to [-8, 8) in Q.28 and offset by +8
   always_comb begin
      in_range = (&z[ACC_W-1:31]) || ~(|z[ACC_W-1:31]);
      priority if (in_range) begin
         u_in = {~z[31], z[30:0]};
      end else if (z[ACC_W-1]) begin
         u_in = '0;
      end else begin
         u_in = '1;
      end
      prod   = u_ff * SIG_K;
      idx_in = prod[32 +: SIG_AW];
      act_in = lut[idx_ff];
      v1_in  = in_valid;
      v2_in  = v1_ff;
      v3_in  = v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      idx_ff <= idx_in;
      act_ff <= act_in;
   end

   assign out_valid = v3_ff;
   assign act       = act_ff;

endmodule
`default_nettype wire

>>> rtl/core/msc_merge.sv
`default_nettype none
module msc_merge import msc_pkg::*; #(
   parameter int N_OUT   = 3,
   parameter int CLASS_W = 2
) (
   input  wire logic                        clock,
   input  wire logic                        in_valid,
   input  wire logic [$clog2(N_OUT)-1:0]    in_index,
   input  wire logic [15:0]                 in_act,
   output logic [15:0]                      act [N_OUT],
   output logic [CLASS_W-1:0]               class_code
);

   localparam int OUT_AW = $clog2(N_OUT);

   logic [15:0]       act_ff [N_OUT];
   logic [15:0]       act_in [N_OUT];
   logic [15:0]       best_ff, best_in;
   logic [OUT_AW-1:0] win_ff, win_in;
   logic              tie_ff, tie_in;

   // running strict maximum; a tie with the current best stands until beaten
   always_comb begin
      act_in  = act_ff;
      best_in = best_ff;
      win_in  = win_ff;
      tie_in  = tie_ff;
      if (in_valid) begin
         act_in[in_index] = in_act;
         priority if (in_index == '0) begin
            best_in = in_act;
            win_in  = in_index;
            tie_in  = 1'b0;
         end else if (in_act > best_ff) begin
            best_in = in_act;
            win_in  = in_index;
            tie_in  = 1'b0;
         end else if (in_act == best_ff) begin
            tie_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      best_ff <= best_in;
      win_ff  <= win_in;
      tie_ff  <= tie_in;
   end

   assign act        = act_ff;
   assign class_code = tie_ff ? CLASS_W'(N_OUT) : CLASS_W'(win_ff);

endmodule
`default_nettype wire

>>> rtl/core/mlp_sigmoid_classifier_top.sv
// Channel   Dir  Ports                         Transfer carries
// req       in   req_tvalid/tready/tdata/tuser cmd, table slot and value, features
// rsp       out  rsp_tvalid/tready/tdata       class code and output activations
//
// A table write is taken with its transfer. A classification runs, before the next item is
// accepted: N_IN and N_HIDDEN MAC steps, one slot a neuron into the shared three-stage sigmoid
// unit and the collection of its results in each layer, the load of the result, then idle.
// Reset clears the weight and bias table to zero, the sequencer and the result valid flag.
// A waiting result stalls only a finished classification; table writes still pass.
`default_nettype none
`include "mlp_sigmoid_classifier_top_macros.svh"
module mlp_sigmoid_classifier_top import msc_pkg::*; #(
   parameter int N_IN        = 4,
   parameter int N_HIDDEN    = 5,
   parameter int N_OUT       = 3,
   parameter int SIG_ENTRIES = 256,
   localparam int TABLE_SIZE = N_IN * N_HIDDEN + N_HIDDEN * N_OUT + N_HIDDEN + N_OUT,
   localparam int IDX_W      = $clog2(TABLE_SIZE),
   localparam int CLASS_W    = $clog2(N_OUT + 1),
   localparam int REQ_W      = ((IDX_W + 16 + 16 * N_IN + 7) / 8) * 8,
   localparam int RSP_W      = ((CLASS_W + 16 * N_OUT + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // from bit 0: table_index, table_value, feat0 .. feat(N_IN-1), zero fill
   input  wire logic [REQ_W-1:0] req_tdata,
   // cmd
   input  wire logic             req_tuser,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // from bit 0: class_code, act0 .. act(N_OUT-1), zero fill
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int N_LANES = (N_HIDDEN > N_OUT) ? N_HIDDEN : N_OUT;
   localparam int MAXS    = (N_IN > N_HIDDEN) ? N_IN : N_HIDDEN;
   localparam int STEP_W  = $clog2(MAXS + 1);
   localparam int CNT_W   = $clog2(N_LANES + 1);
   localparam int LANE_AW = $clog2(N_LANES);
   localparam int IN_AW   = (N_IN > 1) ? $clog2(N_IN) : 1;
   localparam int HID_AW  = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
   localparam int OUT_AW  = $clog2(N_OUT);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   feed_ff, feed_in;   // neurons sent to the sigmoid
   logic [CNT_W-1:0]   ret_ff, ret_in;     // activations come back
   logic [15:0]        feat_ff [N_IN];
   logic [15:0]        feat_in [N_IN];
   logic [15:0]        hid_ff [N_HIDDEN];
   logic [15:0]        hid_in [N_HIDDEN];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic                    wr_en;
   logic                    start_classify;
   logic                    sig_phase;
   lane_ctrl_type           ctrl;
   logic signed [16:0]      operand;
   logic signed [ACC_W-1:0] lane_acc [N_LANES];
   logic                    sig_in_valid;
   logic                    sig_out_valid;
   logic [15:0]             sig_act;
   logic                    merge_valid;
   logic [15:0]             merge_act [N_OUT];
   logic [CLASS_W-1:0]      merge_class;

   assign req_tready     = (state_ff == ST_IDLE);
   assign req_accept     = req_tvalid && req_tready;
   assign wr_en          = req_accept && (req_tuser == CMD_WRITE);
   assign start_classify = req_accept && (req_tuser == CMD_CLASSIFY);
   // a layer's activations are being collected
   assign sig_phase      = (state_ff == ST_HSIG) || (state_ff == ST_OSIG);

   // one lane per neuron of the wider layer
   for (genvar l = 0; l < N_LANES; l++) begin : g_lane
      msc_lane #(
         .LANE     (l),
         .N_IN     (N_IN),
         .N_HIDDEN (N_HIDDEN),
         .N_OUT    (N_OUT),
         .IDX_W    (IDX_W),
         .STEP_W   (STEP_W)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_en    (wr_en),
         .wr_idx   (req_tdata[IDX_W-1:0]),
         .wr_data  (req_tdata[IDX_W +: 16]),
         .step     (step_ff),
         .operand  (operand),
         .acc      (lane_acc[l])
      );
   end

   msc_sigmoid #(
      .SIG_ENTRIES (SIG_ENTRIES)
   ) u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sig_in_valid),
      .z         (lane_acc[feed_ff[LANE_AW-1:0]]),
      .out_valid (sig_out_valid),
      .act       (sig_act)
   );

   assign merge_valid = sig_out_valid && (state_ff == ST_OSIG);

   msc_merge #(
      .N_OUT   (N_OUT),
      .CLASS_W (CLASS_W)
   ) u_merge (
      .clock      (clock),
      .in_valid   (merge_valid),
      .in_index   (ret_ff[OUT_AW-1:0]),
      .in_act     (sig_act),
      .act        (merge_act),
      .class_code (merge_class)
   );

   // shared operand: features in the hidden layer, hidden activations after
   always_comb begin
      if (state_ff == ST_HMAC) begin
         operand = {feat_ff[step_ff[IN_AW-1:0]][15], feat_ff[step_ff[IN_AW-1:0]]};
      end else begin
         operand = {1'b0, hid_ff[step_ff[HID_AW-1:0]]};
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      feed_in      = feed_ff;
      ret_in       = ret_ff;
      feat_in      = feat_ff;
      hid_in       = hid_ff;
      ctrl         = '0;
      sig_in_valid = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start_classify) begin
               for (int p = 0; p < N_IN; p++) begin
                  feat_in[p] = req_tdata[IDX_W + 16 + 16 * p +: 16];
               end
               ctrl.init = 1'b1;
               step_in   = '0;
               state_in  = ST_HMAC;
            end
         end
         ST_HMAC: begin
            ctrl.mac = 1'b1;
            if (step_ff == STEP_W'(N_IN - 1)) begin
               step_in  = '0;
               feed_in  = '0;
               ret_in   = '0;
               state_in = ST_HSIG;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_HSIG: begin
            if (feed_ff < CNT_W'(N_HIDDEN)) begin
               sig_in_valid = 1'b1;
               feed_in      = feed_ff + 1'b1;
            end
            if (sig_out_valid) begin
               hid_in[ret_ff[HID_AW-1:0]] = sig_act;
               ret_in = ret_ff + 1'b1;
               if (ret_ff == CNT_W'(N_HIDDEN - 1)) begin
                  // every sum has left the lanes, so they may reload
                  ctrl.init      = 1'b1;
                  ctrl.out_layer = 1'b1;
                  step_in        = '0;
                  state_in       = ST_OMAC;
               end
            end
         end
         ST_OMAC: begin
            ctrl.mac       = 1'b1;
            ctrl.out_layer = 1'b1;
            if (step_ff == STEP_W'(N_HIDDEN - 1)) begin
               step_in  = '0;
               feed_in  = '0;
               ret_in   = '0;
               state_in = ST_OSIG;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OSIG: begin
            if (feed_ff < CNT_W'(N_OUT)) begin
               sig_in_valid = 1'b1;
               feed_in      = feed_ff + 1'b1;
            end
            if (sig_out_valid) begin
               ret_in = ret_ff + 1'b1;
               if (ret_ff == CNT_W'(N_OUT - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[CLASS_W-1:0] = merge_class;
               for (int n = 0; n < N_OUT; n++) begin
                  rsp_data_in[CLASS_W + 16 * n +: 16] = merge_act[n];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         feed_ff      <= '0;
         ret_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         feed_ff      <= feed_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      feat_ff     <= feat_in;
      hid_ff      <= hid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a new result only ever comes from the final state
   `MSC_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   // sigmoid results only land while a layer is being collected
   `MSC_ASSERT_SAME(a_sig_in_phase, clock, reset, sig_out_valid, sig_phase)
   // never more activations back than sums sent
   `MSC_ASSERT_SAME(a_ret_le_feed, clock, reset, sig_phase, ret_ff <= feed_ff)
   // a classify transfer starts the hidden MAC run
   `MSC_ASSERT_NEXT(a_start_mac, clock, reset, start_classify, state_ff == ST_HMAC)

endmodule
`default_nettype wire
